>>> rtl/cddo_pkg.sv
// Shared types, field widths and constant tables for the civil date day offset block.
// Used by cddo_pipe and civil_date_day_offset; depends on nothing else.
package cddo_pkg;

    localparam int YearW   = 12;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int OffsetW = 18;
    localparam int JdnW    = 22;

    // tdata widths, rounded up to whole bytes
    localparam int InDataW  = 40;
    localparam int OutDataW = 48;

    // day number of the epoch, half-day already folded in
    localparam logic [20:0] JdnBase = 21'd1721014;

    typedef struct packed {
        logic [YearW-1:0]          year;
        logic [MonthW-1:0]         month;
        logic [DayW-1:0]           day_of_month;
        logic signed [OffsetW-1:0] day_offset;
    } item_t;

    typedef struct packed {
        logic [YearW-1:0]  new_year;
        logic [MonthW-1:0] new_month;
        logic [DayW-1:0]   new_day;
        logic [JdnW-1:0]   day_number;
        logic              out_of_range;
    } res_t;

    // (month + 9) / 12
    function automatic logic [1:0] month_carry(input logic [MonthW-1:0] m);
        logic [1:0] r;
        if (m inside {[4'd3:4'd14]}) begin
            r = 2'd1;
        end else if (m == 4'd15) begin
            r = 2'd2;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

    // (275 * month) / 9
    function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd213;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd366;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd427;
            4'd15:   r = 9'd458;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // (2447 * j) / 80, start of month j in the March-based year
    function automatic logic [8:0] month_base(input logic [3:0] j);
        logic [8:0] r;
        case (j)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd397;
            4'd14:   r = 9'd428;
            4'd15:   r = 9'd458;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/cddo_pipe.sv
// Sixteen-stage arithmetic pipeline: date to day number, offset, day number back to date.
// Depends on cddo_pkg; all stages advance together on en.
module cddo_pipe (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  cddo_pkg::item_t  in_item,
    output logic             out_valid,
    output cddo_pkg::res_t   out_res
);

    localparam int Stages = 16;

    typedef struct packed {
        logic [cddo_pkg::YearW-1:0]  year;
        logic [cddo_pkg::MonthW-1:0] month;
        logic [cddo_pkg::DayW-1:0]   day;
    } side_t;

    logic [Stages:1] v_reg;

    side_t                       side_reg [1:15];
    logic [cddo_pkg::JdnW-1:0]   jdn_reg  [2:15];

    // stage 1: date terms
    logic [20:0] a1_next, a1_reg;
    logic [12:0] b1_next, b1_reg;
    logic [20:0] c1_next, c1_reg;
    logic signed [cddo_pkg::OffsetW-1:0] off1_reg, off2_reg;
    logic [12:0] ys;
    logic [14:0] y7;
    logic        cent;
    // stage 2/3
    logic [21:0] jdn_next;
    logic [21:0] la3_next, la3_reg;
    // stages 4..7: n = 4l / 146097
    logic [30:0] p1;
    logic [6:0]  nq4_reg, nq5_reg, n6_next, n6_reg, n7_reg, n8_reg, n9_reg, n10_reg;
    logic [6:0]  n11_reg, n12_reg, n13_reg, n14_reg;
    logic [21:0] la4_reg, la5_reg, la6_reg;
    logic [24:0] nqd5_next, nqd5_reg, rem1, p6_next, p6_reg, pp7;
    logic        c1;
    logic [15:0] lb7_next, lb7_reg, lb8_reg, lb9_reg, lb10_reg;
    // stages 8..10: i = 4000 (l + 1) / 1461001
    logic [16:0] lb1;
    logic [27:0] x2_next, x2_8_reg, x2_9_reg, iqd9_next, iqd9_reg, rem2;
    logic [36:0] p2;
    logic [6:0]  iq8_reg, iq9_reg, i10_next, i10_reg, i11_reg, i12_reg, i13_reg, i14_reg;
    // stage 11
    logic [17:0] q11;
    logic [16:0] lc_sum;
    logic [9:0]  lc11_reg, lc12_reg, lc13_reg, lc14_reg;
    // stages 12..14: j = 80 l / 2447
    logic [16:0] x3;
    logic [20:0] jp;
    logic [14:0] x3_12_reg, x3_13_reg;
    logic [3:0]  jq12_reg, jq13_reg, j14_next, j14_reg;
    logic [15:0] jqd13_next, jqd13_reg, rem3;
    // stage 15/16
    logic [9:0]  kdiff;
    logic        l4;
    logic [4:0]  k15_reg;
    logic [3:0]  mon15_next, mon15_reg;
    logic [15:0] yr15_next, yr15_reg;
    logic        oor;
    cddo_pkg::res_t res_next, res_reg;

    always_comb begin
        cent = !((in_item.year > 12'd1900) ||
                 ((in_item.year == 12'd1900) && (in_item.month >= 4'd3)));
        a1_next = 21'(in_item.year) * 21'd367;
        ys      = 13'(in_item.year) + 13'(cddo_pkg::month_carry(in_item.month));
        y7      = 15'(ys) * 15'd7;
        b1_next = y7[14:2];
        c1_next = 21'(cddo_pkg::days_before(in_item.month)) + 21'(in_item.day_of_month)
                + cddo_pkg::JdnBase + 21'(cent);

        jdn_next = 22'(a1_reg) - 22'(b1_reg) + 22'(c1_reg);
        la3_next = jdn_reg[2] + 22'(off2_reg) + 22'd68569;

        // reciprocal of 146097 at 2^-24, times 4; may come out one low
        p1 = 31'(la3_reg) * 31'd456;

        nqd5_next = 25'(nq4_reg) * 25'd146097;
        rem1      = 25'({la5_reg, 2'b00}) - nqd5_reg;
        c1        = rem1 >= 25'd146097;
        n6_next   = nq5_reg + 7'(c1);
        p6_next   = nqd5_reg + (c1 ? 25'd146097 : 25'd0);

        pp7      = p6_reg + 25'd3;
        lb7_next = 16'(la6_reg - 22'(pp7[24:2]));

        // 4000 * 183 folded into one constant
        lb1     = 17'(lb7_reg) + 17'd1;
        x2_next = 28'(lb1) * 28'd4000;
        p2      = 37'(lb1) * 37'd732000;

        iqd9_next = 28'(iq8_reg) * 28'd1461001;
        rem2      = x2_9_reg - iqd9_reg;
        i10_next  = iq9_reg + 7'(rem2 >= 28'd1461001);

        q11    = 18'(i10_reg) * 18'd1461;
        lc_sum = 17'(lb10_reg) - 17'(q11[17:2]) + 17'd31;

        x3 = 17'(lc11_reg) * 17'd80;
        jp = 21'(lc11_reg) * 21'd1040;

        jqd13_next = 16'(jq12_reg) * 16'd2447;
        rem3       = 16'(x3_13_reg) - jqd13_reg;
        j14_next   = jq13_reg + 4'(rem3 >= 16'd2447);

        kdiff      = lc14_reg - 10'(cddo_pkg::month_base(j14_reg));
        l4         = j14_reg >= 4'd11;
        mon15_next = j14_reg + 4'd2 - (l4 ? 4'd12 : 4'd0);
        yr15_next  = 16'(n14_reg) * 16'd100 + 16'(i14_reg) + 16'(l4) - 16'd4900;

        oor = ($signed(yr15_reg) < 16'sd1901) || ($signed(yr15_reg) > 16'sd2099);
        res_next.new_year     = oor ? side_reg[15].year  : yr15_reg[11:0];
        res_next.new_month    = oor ? side_reg[15].month : mon15_reg;
        res_next.new_day      = oor ? side_reg[15].day   : k15_reg;
        res_next.day_number   = jdn_reg[15];
        res_next.out_of_range = oor;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[Stages-1:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[1] <= '{year: in_item.year, month: in_item.month,
                             day: in_item.day_of_month};
            for (int s = 2; s <= 15; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            jdn_reg[2] <= jdn_next;
            for (int s = 3; s <= 15; s++) begin
                jdn_reg[s] <= jdn_reg[s-1];
            end

            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
            c1_reg   <= c1_next;
            off1_reg <= in_item.day_offset;
            off2_reg <= off1_reg;

            la3_reg <= la3_next;

            la4_reg <= la3_reg;
            nq4_reg <= p1[30:24];

            la5_reg  <= la4_reg;
            nq5_reg  <= nq4_reg;
            nqd5_reg <= nqd5_next;

            la6_reg <= la5_reg;
            n6_reg  <= n6_next;
            p6_reg  <= p6_next;

            lb7_reg <= lb7_next;
            n7_reg  <= n6_reg;

            lb8_reg  <= lb7_reg;
            n8_reg   <= n7_reg;
            x2_8_reg <= x2_next;
            iq8_reg  <= p2[34:28];

            lb9_reg  <= lb8_reg;
            n9_reg   <= n8_reg;
            x2_9_reg <= x2_8_reg;
            iq9_reg  <= iq8_reg;
            iqd9_reg <= iqd9_next;

            lb10_reg <= lb9_reg;
            n10_reg  <= n9_reg;
            i10_reg  <= i10_next;

            lc11_reg <= lc_sum[9:0];
            i11_reg  <= i10_reg;
            n11_reg  <= n10_reg;

            lc12_reg  <= lc11_reg;
            i12_reg   <= i11_reg;
            n12_reg   <= n11_reg;
            x3_12_reg <= x3[14:0];
            jq12_reg  <= jp[18:15];

            lc13_reg   <= lc12_reg;
            i13_reg    <= i12_reg;
            n13_reg    <= n12_reg;
            x3_13_reg  <= x3_12_reg;
            jq13_reg   <= jq12_reg;
            jqd13_reg  <= jqd13_next;

            lc14_reg <= lc13_reg;
            i14_reg  <= i13_reg;
            n14_reg  <= n13_reg;
            j14_reg  <= j14_next;

            k15_reg   <= kdiff[4:0];
            mon15_reg <= mon15_next;
            yr15_reg  <= yr15_next;

            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[Stages];
    assign out_res   = res_reg;

endmodule

>>> rtl/civil_date_day_offset.sv
// Usage
// Shifts a Gregorian date by a signed number of days and returns the new date together
// with the Julian day number of the starting date.
// Input channel s_*: one item per handshake, tdata holds year, month, day and offset.
// Result channel m_*: exactly one item per input item, in order; tuser flags a shifted
// year outside 1901..2099, in which case the date fields repeat the input date.
// Throughput: one item per cycle while the receiver does not stall, set by the 16-stage
// arithmetic pipeline with its constant-reciprocal divide steps.
// Reset (aresetn low, synchronous) empties the pipeline and the input holding register;
// no results are pending afterwards.
// When the receiver stalls, the whole pipeline holds; one further item is taken into a
// holding register, then s_tready drops until the stall clears. Nothing is lost or
// repeated.
// Depends on cddo_pkg and cddo_pipe.
module civil_date_day_offset (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // year[11:0], month[15:12], day_of_month[20:16], day_offset[38:21], zero pad
    input  logic [cddo_pkg::InDataW-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_year[11:0], new_month[15:12], new_day[20:16], day_number[42:21], zero pad
    output logic [cddo_pkg::OutDataW-1:0]  m_tdata,
    // out_of_range
    output logic                           m_tuser
);

    cddo_pkg::item_t s_item;
    cddo_pkg::item_t skid_reg;
    cddo_pkg::item_t feed_item;
    cddo_pkg::res_t  res;
    logic            skid_v_reg, skid_v_next;
    logic            adv, feed_valid;

    always_comb begin
        s_item.year         = s_tdata[11:0];
        s_item.month        = s_tdata[15:12];
        s_item.day_of_month = s_tdata[20:16];
        s_item.day_offset   = $signed(s_tdata[38:21]);
    end

    assign s_tready   = !skid_v_reg;
    assign adv        = !m_tvalid || m_tready;
    assign feed_valid = skid_v_reg || s_tvalid;
    assign feed_item  = skid_v_reg ? skid_reg : s_item;

    always_comb begin
        skid_v_next = skid_v_reg;
        if (adv) begin
            skid_v_next = 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_v_reg <= 1'b0;
        end else begin
            skid_v_reg <= skid_v_next;
        end
    end

    // holding register only loads while the pipeline is stalled
    always_ff @(posedge aclk) begin
        if (!adv && s_tvalid && s_tready) begin
            skid_reg <= s_item;
        end
    end

    cddo_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (feed_valid),
        .in_item   (feed_item),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = {5'b0, res.day_number, res.new_day, res.new_month, res.new_year};
    assign m_tuser = res.out_of_range;

endmodule

>>> sim/tb_civil_date_day_offset.sv
// Testbench for civil_date_day_offset: drives dated items with signed day offsets and
// checks each shifted date, day number and range flag against a built-in predictor.
// Depends on cddo_pkg and the civil_date_day_offset RTL only.
`timescale 1ns / 1ps

module tb_civil_date_day_offset;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 40;

    // Holds the shifted dates still owed by the block, oldest first
    class date_shift_scoreboard;
        cddo_pkg::res_t shifted_dates_q[$];
        int   fails;

        function new();
            fails = 0;
        endfunction

        task report_mismatch(input string what, input longint got, input longint want);
            fails++;
            if (fails <= 50) begin
                $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            end
        endtask

        // Julian day number by the 367 * y formula, then back by Fliegel-Van Flandern
        function cddo_pkg::res_t shift_date(input cddo_pkg::item_t it);
            cddo_pkg::res_t r;
            longint y, m, d, off, jdn, l, n, i, j, k;
            y   = longint'(it.year);
            m   = longint'(it.month);
            d   = longint'(it.day_of_month);
            off = $signed({{46{it.day_offset[cddo_pkg::OffsetW-1]}}, it.day_offset});
            jdn = 367 * y - (7 * (y + (m + 9) / 12)) / 4 + (275 * m) / 9 + d + 1721014;
            // dates up to February 1900 take one more day
            if (100 * y + m < 190003) begin
                jdn = jdn + 1;
            end
            l = jdn + off + 68569;
            n = (4 * l) / 146097;
            l = l - (146097 * n + 3) / 4;
            i = (4000 * (l + 1)) / 1461001;
            l = l - (1461 * i) / 4 + 31;
            j = (80 * l) / 2447;
            k = l - (2447 * j) / 80;
            l = j / 11;
            j = j + 2 - 12 * l;
            i = 100 * (n - 49) + i + l;
            if (i < 1901 || i > 2099) begin
                r.new_year     = it.year;
                r.new_month    = it.month;
                r.new_day      = it.day_of_month;
                r.out_of_range = 1'b1;
            end else begin
                r.new_year     = i[cddo_pkg::YearW-1:0];
                r.new_month    = j[cddo_pkg::MonthW-1:0];
                r.new_day      = k[cddo_pkg::DayW-1:0];
                r.out_of_range = 1'b0;
            end
            r.day_number = jdn[cddo_pkg::JdnW-1:0];
            return r;
        endfunction

        function void note_date(input logic [cddo_pkg::InDataW-1:0] data);
            cddo_pkg::item_t it;
            it.year         = data[11:0];
            it.month        = data[15:12];
            it.day_of_month = data[20:16];
            it.day_offset   = data[38:21];
            shifted_dates_q.push_back(shift_date(it));
        endfunction

        task check_shifted(input logic [cddo_pkg::OutDataW-1:0] data, input logic flag);
            cddo_pkg::res_t want;
            if (shifted_dates_q.size() == 0) begin
                report_mismatch("result with nothing outstanding, day_number",
                                longint'(data[42:21]), 0);
            end else begin
                want = shifted_dates_q.pop_front();
                if (data[11:0] !== want.new_year)
                    report_mismatch("new_year", longint'(data[11:0]),
                                    longint'(want.new_year));
                if (data[15:12] !== want.new_month)
                    report_mismatch("new_month", longint'(data[15:12]),
                                    longint'(want.new_month));
                if (data[20:16] !== want.new_day)
                    report_mismatch("new_day", longint'(data[20:16]),
                                    longint'(want.new_day));
                if (data[42:21] !== want.day_number)
                    report_mismatch("day_number", longint'(data[42:21]),
                                    longint'(want.day_number));
                if (flag !== want.out_of_range)
                    report_mismatch("out_of_range", longint'(flag),
                                    longint'(want.out_of_range));
            end
        endtask
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [cddo_pkg::InDataW-1:0]  s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [cddo_pkg::OutDataW-1:0] m_tdata;
    logic                          m_tuser;

    date_shift_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;
    int cycle_count;

    civil_date_day_offset dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_date(s_tdata);
            if (m_tvalid && m_tready) sb.check_shifted(m_tdata, m_tuser);
        end
    end

    // Receiver: random back-pressure, or a counted hold-off when one is requested
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Offers one item after a random idle spell and returns at the edge that accepts it
    task automatic send_date(input cddo_pkg::item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, it.day_offset, it.day_of_month, it.month, it.year};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(input int y, input int m, input int d, input int off);
        cddo_pkg::item_t it;
        it.year         = y[cddo_pkg::YearW-1:0];
        it.month        = m[cddo_pkg::MonthW-1:0];
        it.day_of_month = d[cddo_pkg::DayW-1:0];
        it.day_offset   = off[cddo_pkg::OffsetW-1:0];
        send_date(it);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.shifted_dates_q.size() != 0) @(posedge aclk);
    endtask

    // Mostly sane dates; some near the years 1901 and 2099; some raw bit patterns
    function automatic cddo_pkg::item_t random_date();
        cddo_pkg::item_t it;
        int    sel;
        int    off;
        sel = $urandom_range(99);
        it.year         = 12'($urandom_range(2099, 1901));
        it.month        = 4'($urandom_range(12, 1));
        it.day_of_month = 5'($urandom_range(28, 1));
        if (sel < 55) begin
            off = $urandom_range(146000) - 73000;
        end else if (sel < 72) begin
            off = $urandom_range(800) - 400;
        end else if (sel < 85) begin
            it.year         = ($urandom_range(1)) ? 12'd1901 : 12'd2099;
            it.day_of_month = 5'($urandom_range(31, 1));
            off = $urandom_range(1600) - 800;
        end else begin
            it.year         = 12'($urandom());
            it.month        = 4'($urandom());
            it.day_of_month = 5'($urandom());
            off = $urandom();
        end
        it.day_offset = off[cddo_pkg::OffsetW-1:0];
        return it;
    endfunction

    initial begin
        sb = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rx_hold     = 0;
        tx_idle_pct = 26;
        rx_idle_pct = 64;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_fields(1901, 1, 1, 0);
        send_fields(2099, 12, 31, 0);
        send_fields(1901, 1, 1, -1);
        send_fields(2099, 12, 31, 1);
        send_fields(2000, 2, 29, 0);
        send_fields(2000, 2, 28, 1);
        send_fields(2000, 3, 1, -1);
        // either side of the February 1900 century term
        send_fields(1900, 2, 28, 366);
        send_fields(1900, 3, 1, 365);
        send_fields(1999, 12, 31, 1);
        send_fields(2050, 6, 15, 73000);
        send_fields(2050, 6, 15, -73000);
        send_fields(2099, 12, 31, -73000);
        send_fields(1901, 1, 1, 73000);
        send_fields(2000, 1, 1, 131071);
        send_fields(2000, 1, 1, -131072);
        send_fields(0, 0, 0, 0);
        send_fields(4095, 15, 31, -1);
        send_fields(2010, 0, 10, 0);
        send_fields(2010, 15, 10, 0);
        send_fields(2010, 2, 0, 0);
        send_fields(2010, 2, 31, 0);
        send_fields(1904, 2, 29, 365);

        repeat (450) send_date(random_date());
        wait_drained();

        tx_idle_pct = 64;
        rx_idle_pct = 26;
        repeat (450) send_date(random_date());

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long receiver hold-off while items keep coming, so the input stalls
        rx_hold = 300;
        repeat (80) send_date(random_date());
        repeat (400) send_date(random_date());

        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
